// File: hw/rtl/bale_pkg.sv
// bale_pkg: shared sizes, op and status codes for the bounded array list engine
// no dependencies; compiled first
package bale_pkg;

    localparam int CAPACITY  = 256;
    localparam int WORD_BITS = 32;

    // derived widths
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [AW-1:0]        t_addr;
    typedef logic [CW-1:0]        t_count;

    typedef enum logic [3:0] {
        OP_ADD_FRONT    = 4'd0,
        OP_ADD_BACK     = 4'd1,
        OP_GET          = 4'd2,
        OP_SET          = 4'd3,
        OP_REMOVE_VALUE = 4'd4,
        OP_REMOVE_FIRST = 4'd5,
        OP_REMOVE_LAST  = 4'd6,
        OP_CONTAINS     = 4'd7,
        OP_FIRST        = 4'd8,
        OP_LAST         = 4'd9
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NULL   = 3'd1,
        ST_BOUNDS = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4,
        ST_ABSENT = 3'd5
    } t_status;

endpackage

// File: hw/rtl/bale_if.sv
// bale_if: request and response channels of the bounded array list engine
// depends on nothing; fixed field widths
interface bale_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [7:0]  position;
    logic [31:0] value;

    modport source (output valid, op, position, value, input ready);
    modport sink   (input valid, op, position, value, output ready);
endinterface

interface bale_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic        found;
    logic [8:0]  count;
    logic        empty_flag;

    modport source (output valid, status, value_out, found, count, empty_flag, input ready);
    modport sink   (input valid, status, value_out, found, count, empty_flag, output ready);
endinterface

// File: hw/rtl/bale_ram.sv
// bale_ram: generic simple dual-port ram, one write and one registered read port
// no package dependency
module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bounded_array_list_engine.sv
// bounded_array_list_engine: ordered list of nonzero words kept in one ram
// depends on bale_pkg, bale_if and bale_ram
//
//  channel  | dir | modport | beat carries
//  ---------+-----+---------+---------------------------------------------
//  i_req    | in  | sink    | op, position, value
//  o_rsp    | out | source  | status, value_out, found, count, empty_flag
//
// one request at a time; every request gives exactly one response beat
// add back, set, undefined ops, errors and add front or contains on an empty list
//   go straight to the result; get, first and last add a ram read; remove last
//   reads the last entry and drops it; contains, remove value and remove first walk
//   the ram one entry a cycle; add front on a non-empty list shifts every entry up
//   the single ram read port and single write port force these entry-by-entry walks
// synchronous active-low reset clears the count and the control; ram contents
//   are not cleared, only entries below the count are ever read
// the response sits in an output register, so a stalled o_rsp holds the engine
//   only once the next result is ready to leave
module bounded_array_list_engine
    import bale_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    bale_req_if.sink      i_req,
    bale_rsp_if.source    o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SEARCH   = 7'b0000010,  // compare entry at r_ptr, read the next one
        S_SHIFT_UP = 7'b0000100,  // copy entry r_ptr to r_ptr+1, walking down
        S_PUT      = 7'b0001000,  // drop the new word into entry 0
        S_SHIFT_DN = 7'b0010000,  // copy entry r_ptr to r_ptr-1, walking up
        S_READ     = 7'b0100000,  // capture a single read
        S_RESULT   = 7'b1000000   // hand the result to the output register
    } t_state;

    t_state  r_state, n_state;
    t_addr   r_ptr, n_ptr;
    t_count  r_count, n_count;
    t_word   r_val, n_val;
    logic    r_any, n_any;        // first read entry is the match (remove first/last)
    logic    r_remove, n_remove;  // search ends in removal rather than a found flag
    t_status r_status, n_status;
    t_word   r_rd, n_rd;
    logic    r_found, n_found;

    // output register
    logic    r_o_valid;
    t_status r_o_status;
    t_word   r_o_rd;
    logic    r_o_found;
    t_count  r_o_count;

    // ram ports
    logic    ram_we;
    t_addr   ram_waddr;
    t_word   ram_wdata;
    t_addr   ram_raddr;
    t_word   ram_rdata;

    bale_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request decode
    logic  req_fire;
    t_op   req_op;
    t_word req_val;
    logic  req_needs_val;
    logic  req_bad_pos;
    logic  list_empty;
    logic  list_full;
    t_addr last_addr;
    logic  ptr_at_last;
    logic  load_out;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign req_op      = t_op'(i_req.op);
    assign req_val     = t_word'(i_req.value);

    assign req_needs_val = (req_op == OP_ADD_FRONT) || (req_op == OP_ADD_BACK)
                        || (req_op == OP_SET) || (req_op == OP_REMOVE_VALUE)
                        || (req_op == OP_CONTAINS);
    assign req_bad_pos   = CMPW'(i_req.position) >= CMPW'(r_count);

    assign list_empty  = (r_count == '0);
    assign list_full   = (r_count >= CW'(CAPACITY));
    assign last_addr   = AW'(r_count - CW'(1));
    assign ptr_at_last = (CW'(r_ptr) == (r_count - CW'(1)));

    assign load_out = (r_state == S_RESULT) && (!r_o_valid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_val     = r_val;
        n_any     = r_any;
        n_remove  = r_remove;
        n_status  = r_status;
        n_rd      = r_rd;
        n_found   = r_found;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = r_val;
        ram_raddr = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_val    = req_val;
                    n_rd     = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_any    = 1'b0;
                    n_remove = 1'b0;
                    n_state  = S_RESULT;
                    if (req_needs_val && (req_val == '0)) begin
                        n_status = ST_NULL;
                    end else begin
                        case (req_op)
                            OP_ADD_FRONT: begin
                                if (list_full) begin
                                    n_status = ST_FULL;
                                end else if (list_empty) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    ram_wdata = req_val;
                                    n_count   = r_count + CW'(1);
                                end else begin
                                    ram_raddr = last_addr;
                                    n_ptr     = last_addr;
                                    n_state   = S_SHIFT_UP;
                                end
                            end
                            OP_ADD_BACK: begin
                                if (list_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = AW'(r_count);
                                    ram_wdata = req_val;
                                    n_count   = r_count + CW'(1);
                                end
                            end
                            OP_GET: begin
                                if (req_bad_pos) begin
                                    n_status = ST_BOUNDS;
                                end else begin
                                    ram_raddr = AW'(i_req.position);
                                    n_state   = S_READ;
                                end
                            end
                            OP_SET: begin
                                if (req_bad_pos) begin
                                    n_status = ST_BOUNDS;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = AW'(i_req.position);
                                    ram_wdata = req_val;
                                end
                            end
                            OP_REMOVE_VALUE: begin
                                if (list_empty) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    ram_raddr = '0;
                                    n_ptr     = '0;
                                    n_remove  = 1'b1;
                                    n_state   = S_SEARCH;
                                end
                            end
                            OP_REMOVE_FIRST: begin
                                if (list_empty) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    ram_raddr = '0;
                                    n_ptr     = '0;
                                    n_any     = 1'b1;
                                    n_remove  = 1'b1;
                                    n_state   = S_SEARCH;
                                end
                            end
                            OP_REMOVE_LAST: begin
                                if (list_empty) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    ram_raddr = last_addr;
                                    n_ptr     = last_addr;
                                    n_any     = 1'b1;
                                    n_remove  = 1'b1;
                                    n_state   = S_SEARCH;
                                end
                            end
                            OP_CONTAINS: begin
                                // empty list: not found, status stays ok
                                if (!list_empty) begin
                                    ram_raddr = '0;
                                    n_ptr     = '0;
                                    n_state   = S_SEARCH;
                                end
                            end
                            OP_FIRST: begin
                                if (list_empty) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    ram_raddr = '0;
                                    n_state   = S_READ;
                                end
                            end
                            OP_LAST: begin
                                if (list_empty) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    ram_raddr = last_addr;
                                    n_state   = S_READ;
                                end
                            end
                            default: begin
                                // unused op codes: plain ok, nothing changes
                            end
                        endcase
                    end
                end
            end

            S_SEARCH: begin
                if (r_any || (ram_rdata == r_val)) begin
                    if (r_remove) begin
                        n_rd = ram_rdata;
                        if (ptr_at_last) begin
                            n_count = r_count - CW'(1);
                            n_state = S_RESULT;
                        end else begin
                            ram_raddr = r_ptr + AW'(1);
                            n_ptr     = r_ptr + AW'(1);
                            n_state   = S_SHIFT_DN;
                        end
                    end else begin
                        n_found = 1'b1;
                        n_state = S_RESULT;
                    end
                end else if (ptr_at_last) begin
                    if (r_remove) begin
                        n_status = ST_ABSENT;
                    end
                    n_state = S_RESULT;
                end else begin
                    ram_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end

            S_SHIFT_DN: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr - AW'(1);
                ram_wdata = ram_rdata;
                if (ptr_at_last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESULT;
                end else begin
                    ram_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end

            S_SHIFT_UP: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr + AW'(1);
                ram_wdata = ram_rdata;
                if (r_ptr == '0) begin
                    n_state = S_PUT;
                end else begin
                    ram_raddr = r_ptr - AW'(1);
                    n_ptr     = r_ptr - AW'(1);
                end
            end

            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_state   = S_RESULT;
            end

            S_READ: begin
                n_rd    = ram_rdata;
                n_state = S_RESULT;
            end

            S_RESULT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_val    <= n_val;
        r_any    <= n_any;
        r_remove <= n_remove;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_found  <= n_found;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_rd     <= r_rd;
            r_o_found  <= r_found;
            r_o_count  <= r_count;
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.value_out  = 32'(r_o_rd);
    assign o_rsp.found      = r_o_found;
    assign o_rsp.count      = 9'(r_o_count);
    assign o_rsp.empty_flag = (r_o_count == '0);

endmodule
